/* hdl/sati_pkg.sv */
// Shared types, status codes and key lowering for the sorted abbreviation table.
package sati_pkg;

  localparam int KeyBytes = 10;
  localparam int KeyW     = 80;
  localparam int ValW     = 18;

  localparam logic [2:0] ST_INSERTED   = 3'd0;
  localparam logic [2:0] ST_SAME       = 3'd1;
  localparam logic [2:0] ST_OVERRIDDEN = 3'd2;
  localparam logic [2:0] ST_CONFLICT   = 3'd3;
  localparam logic [2:0] ST_NOT_STEP   = 3'd4;
  localparam logic [2:0] ST_RANGE      = 3'd5;
  localparam logic [2:0] ST_FULL       = 3'd6;
  localparam logic [2:0] ST_READ       = 3'd7;

  // per-cell control, broadcast from the top level
  typedef struct packed {
    logic              cmp;
    logic              ins;
    logic              ovr;
    logic              is_read;
    logic [KeyW-1:0]   key;
    logic [ValW-1:0]   val;
    logic [7:0]        ridx;
  } sati_ctrl_t;

  // neighbor link: cell i hands its state to cell i+1
  typedef struct packed {
    logic              lt;
    logic [KeyW-1:0]   key;
    logic [ValW-1:0]   val;
  } sati_link_t;

  // per-cell flags toward the top level
  typedef struct packed {
    logic              bnd;
    logic              eq;
    logic              same;
    logic [KeyW-1:0]   tap_key;
    logic [ValW-1:0]   tap_val;
  } sati_flag_t;

  // clear bytes past the key length or after the first zero, then lower A..Z
  function automatic logic [KeyW-1:0] sati_lower(logic [KeyW-1:0] k);
    logic [KeyW-1:0] r;
    logic            ended;
    logic [7:0]      b;
    r     = k;
    ended = 1'b0;
    for (int i = 0; i < 10; i++) begin
      b = k[KeyW-1-8*i -: 8];
      if (i >= KeyBytes || ended) begin
        b = 8'h00;
      end
      if (b == 8'h00) begin
        ended = 1'b1;
      end
      if (b >= 8'h41 && b <= 8'h5a) begin
        b = b + 8'h20;
      end
      r[KeyW-1-8*i -: 8] = b;
    end
    return r;
  endfunction

endpackage

/* hdl/sorted_abbrev_table_insert.sv */
// Sorted zone abbreviation table built as a chain of compare-and-shift cells.
// The result word is registered when the update state completes, after the compare state.
// A new request is taken only in the idle state; all cells compare in the compare state and shift in the update state.
// A result word still waiting on the output holds the update cycle until it is taken.
// Reset: entry count cleared; table contents are undefined until written.
// An output register holds the result word so a request is taken while it waits.
module sorted_abbrev_table_insert #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // key_high[15:0], key_low[79:16], offset_seconds[97:80], dst_flag[98],
  // override_enable[99], read_index[107:100]
  input  logic [111:0] s_axis_tdata,
  // req_type[0]
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // status[2:0], position[11:3], entry_count[20:12], out_key_high[36:21],
  // out_key_low[100:37], out_offset[117:101], out_dst[118]
  output logic [119:0] m_axis_tdata
);
  import sati_pkg::*;

  localparam int CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CMP  = 3'b010,
    S_UPD  = 3'b100
  } state_e;

  state_e            state_q, state_d;
  logic [CW-1:0]     count_q, count_d;
  logic              out_valid_q;
  logic [119:0]      out_data_q, out_data_d;

  logic              is_read_q, dst_q, ovr_q;
  logic [KeyW-1:0]   key_q;
  logic signed [17:0] off_q;
  logic [7:0]        ridx_q;
  logic              bad_step_q, bad_range_q;

  logic              in_fire, upd_fire;
  logic [17:0]       off_abs;
  logic [15:0]       step_prod;
  logic              step_ok, range_ok;
  logic [ValW-1:0]   newval;

  sati_ctrl_t        ctrl;
  sati_link_t        link [TABLE_DEPTH+1];
  sati_flag_t        flag [TABLE_DEPTH];

  logic [TABLE_DEPTH-1:0] bnd_vec, eq_vec, same_vec;
  logic              hit, same;
  logic [CW-1:0]     pos;
  logic [KeyW-1:0]   tap_key;
  logic [ValW-1:0]   tap_val;
  logic              do_ins, do_ovr;
  logic [2:0]        st;
  logic [CW-1:0]     r_pos;
  logic [KeyW-1:0]   r_key;
  logic [ValW-1:0]   r_val;

  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);
  assign upd_fire      = (state_q == S_UPD) && (!out_valid_q || m_axis_tready);

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      is_read_q <= s_axis_tuser;
      key_q     <= sati_lower({s_axis_tdata[15:0], s_axis_tdata[79:16]});
      off_q     <= s_axis_tdata[97:80];
      dst_q     <= s_axis_tdata[98];
      ovr_q     <= s_axis_tdata[99];
      ridx_q    <= s_axis_tdata[107:100];
    end
    if (state_q == S_CMP) begin
      bad_step_q  <= !step_ok;
      bad_range_q <= !range_ok;
    end
  end

  // multiple of 900: divisible by 4, and the quarter divisible by 225 (inverse test)
  assign off_abs   = off_q[17] ? 18'(-off_q) : 18'(off_q);
  assign step_prod = 16'(off_abs[17:2] * 16'd17185);
  assign step_ok   = (off_abs[1:0] == 2'b00) && (step_prod <= 16'd291);
  assign range_ok  = (off_q <= 18'sd50400) && (off_q >= -18'sd50400);
  assign newval    = {dst_q, off_q[16:0]};

  assign ctrl.cmp     = (state_q == S_CMP);
  assign ctrl.ins     = upd_fire && do_ins;
  assign ctrl.ovr     = upd_fire && do_ovr;
  assign ctrl.is_read = is_read_q;
  assign ctrl.key     = key_q;
  assign ctrl.val     = newval;
  assign ctrl.ridx    = ridx_q;

  assign link[0].lt  = 1'b1;
  assign link[0].key = '0;
  assign link[0].val = '0;

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    sati_cell #(.INDEX(g), .CW(CW)) u_cell (
      .clk_i  (clk_i),
      .ctrl_i (ctrl),
      .count_i(count_q),
      .prev_i (link[g]),
      .link_o (link[g+1]),
      .flag_o (flag[g])
    );
    assign bnd_vec[g]  = flag[g].bnd;
    assign eq_vec[g]   = flag[g].eq;
    assign same_vec[g] = flag[g].same;
  end

  assign hit  = |eq_vec;
  assign same = |same_vec;

  always_comb begin
    pos     = '0;
    tap_key = '0;
    tap_val = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (bnd_vec[i]) begin
        pos = pos | CW'(i);
      end
      tap_key = tap_key | flag[i].tap_key;
      tap_val = tap_val | flag[i].tap_val;
    end
    if (link[TABLE_DEPTH].lt) begin
      pos = CW'(TABLE_DEPTH);
    end
  end

  always_comb begin
    do_ins  = 1'b0;
    do_ovr  = 1'b0;
    count_d = count_q;
    r_pos   = pos;
    r_key   = key_q;
    r_val   = newval;
    if (is_read_q) begin
      st    = ST_READ;
      r_pos = CW'(ridx_q);
      r_key = tap_key;
      r_val = tap_val;
    end else if (bad_step_q || bad_range_q) begin
      st    = bad_step_q ? ST_NOT_STEP : ST_RANGE;
      r_pos = '0;
      r_val = '0;
    end else if (hit) begin
      if (same) begin
        st = ST_SAME;
      end else if (ovr_q) begin
        st     = ST_OVERRIDDEN;
        do_ovr = 1'b1;
      end else begin
        st    = ST_CONFLICT;
        r_val = tap_val;
      end
    end else if (count_q == CW'(TABLE_DEPTH)) begin
      st    = ST_FULL;
      r_val = '0;
    end else begin
      st      = ST_INSERTED;
      do_ins  = 1'b1;
      count_d = count_q + 1'b1;
    end
    out_data_d = {1'b0, r_val[17], r_val[16:0], r_key[63:0], r_key[79:64],
                  9'(count_d), 9'(r_pos), st};
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_fire) state_d = S_CMP;
      S_CMP:  state_d = S_UPD;
      S_UPD:  if (upd_fire) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (upd_fire) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd_fire) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  a_accept_to_cmp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q == S_CMP) else $error("accept did not start compare");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(TABLE_DEPTH)) else $error("entry count past depth");
  a_one_boundary: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_UPD |-> $onehot0(bnd_vec)) else $error("several insert points");
  a_one_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_UPD |-> $onehot0(eq_vec)) else $error("duplicate keys in table");
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(count_q) |-> $past(upd_fire)) else $error("count moved outside update");

endmodule

/* hdl/sati_cell.sv */
// One table slot: holds a key and value, compares, and shifts from its left neighbor.
module sati_cell #(
  parameter int INDEX = 0,
  parameter int CW    = 9
) (
  input  logic                 clk_i,
  input  sati_pkg::sati_ctrl_t ctrl_i,
  input  logic [CW-1:0]        count_i,
  input  sati_pkg::sati_link_t prev_i,
  output sati_pkg::sati_link_t link_o,
  output sati_pkg::sati_flag_t flag_o
);
  import sati_pkg::*;

  localparam int RW = (CW > 8) ? CW : 8;

  logic [KeyW-1:0] key_q;
  logic [ValW-1:0] val_q;
  logic            lt_q, eq_q, same_q;
  logic [KeyW-1:0] tap_key_q;
  logic [ValW-1:0] tap_val_q;
  logic            valid, lt_d, eq_d, rd_d, bnd;

  assign valid = CW'(INDEX) < count_i;
  assign lt_d  = valid && (ctrl_i.key > key_q);
  assign eq_d  = valid && !ctrl_i.is_read && (ctrl_i.key == key_q);
  assign rd_d  = valid && ctrl_i.is_read && (RW'(INDEX) == RW'(ctrl_i.ridx));
  assign bnd   = prev_i.lt && !lt_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.cmp) begin
      lt_q      <= lt_d;
      eq_q      <= eq_d;
      same_q    <= eq_d && (val_q == ctrl_i.val);
      tap_key_q <= (eq_d || rd_d) ? key_q : '0;
      tap_val_q <= (eq_d || rd_d) ? val_q : '0;
    end
    if (ctrl_i.ins) begin
      if (!prev_i.lt) begin
        key_q <= prev_i.key;
        val_q <= prev_i.val;
      end else if (bnd) begin
        key_q <= ctrl_i.key;
        val_q <= ctrl_i.val;
      end
    end else if (ctrl_i.ovr && eq_q) begin
      val_q <= ctrl_i.val;
    end
  end

  assign link_o.lt      = lt_q;
  assign link_o.key     = key_q;
  assign link_o.val     = val_q;
  assign flag_o.bnd     = bnd;
  assign flag_o.eq      = eq_q;
  assign flag_o.same    = same_q;
  assign flag_o.tap_key = tap_key_q;
  assign flag_o.tap_val = tap_val_q;

endmodule
